// ===== rtl/core/cpualu_pkg.sv =====
package cpualu_pkg;

  // Operation codes carried in the opcode field.
  localparam logic [4:0] OP_ADD    = 5'd0;
  localparam logic [4:0] OP_ADC    = 5'd1;
  localparam logic [4:0] OP_SUB    = 5'd2;
  localparam logic [4:0] OP_SBC    = 5'd3;
  localparam logic [4:0] OP_AND    = 5'd4;
  localparam logic [4:0] OP_XOR    = 5'd5;
  localparam logic [4:0] OP_OR     = 5'd6;
  localparam logic [4:0] OP_CP     = 5'd7;
  localparam logic [4:0] OP_INC    = 5'd8;
  localparam logic [4:0] OP_DEC    = 5'd9;
  localparam logic [4:0] OP_DAA    = 5'd10;
  localparam logic [4:0] OP_CPL    = 5'd11;
  localparam logic [4:0] OP_SCF    = 5'd12;
  localparam logic [4:0] OP_CCF    = 5'd13;
  localparam logic [4:0] OP_RLCA   = 5'd14;
  localparam logic [4:0] OP_RLA    = 5'd15;
  localparam logic [4:0] OP_RRCA   = 5'd16;
  localparam logic [4:0] OP_RRA    = 5'd17;
  localparam logic [4:0] OP_RLC    = 5'd18;
  localparam logic [4:0] OP_RL     = 5'd19;
  localparam logic [4:0] OP_RRC    = 5'd20;
  localparam logic [4:0] OP_RR     = 5'd21;
  localparam logic [4:0] OP_SLA    = 5'd22;
  localparam logic [4:0] OP_SRA    = 5'd23;
  localparam logic [4:0] OP_SRL    = 5'd24;
  localparam logic [4:0] OP_SWAP   = 5'd25;
  localparam logic [4:0] OP_BIT    = 5'd26;
  localparam logic [4:0] OP_RES    = 5'd27;
  localparam logic [4:0] OP_SET    = 5'd28;
  localparam logic [4:0] OP_ADD16  = 5'd29;
  localparam logic [4:0] OP_ADD_SP = 5'd30;

  // Flag bit positions.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Decimal adjust constants.
  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_MAX = 8'h99;
  localparam logic [3:0] DAA_LO_MAX = 4'h9;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [3:0]  flags_out;
    logic        result_valid;
  } out_item_t;

endpackage

// ===== rtl/core/cpualu_exec.sv =====
module cpualu_exec (
  input  cpualu_pkg::in_item_t  item,
  output cpualu_pkg::out_item_t res
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        zi, ni, hi, ci;
  logic        add_ci, sub_ci;
  logic [8:0]  add_sum;
  logic [4:0]  add_nib;
  logic [8:0]  sub_dif;
  logic [4:0]  sub_nib;
  logic        daa_hi, daa_lo;
  logic [7:0]  daa_adj;
  logic [7:0]  daa_val;
  logic [7:0]  bit_mask;
  logic [16:0] w_sum;
  logic [12:0] w_low;
  logic [15:0] sp_off;
  logic [15:0] sp_sum;
  logic [4:0]  sp_nib;
  logic [8:0]  sp_byte;

  assign a  = item.operand_a[7:0];
  assign b  = item.operand_b[7:0];
  assign zi = item.flags_in[cpualu_pkg::FLAG_Z];
  assign ni = item.flags_in[cpualu_pkg::FLAG_N];
  assign hi = item.flags_in[cpualu_pkg::FLAG_H];
  assign ci = item.flags_in[cpualu_pkg::FLAG_C];

  assign add_ci  = (item.opcode == cpualu_pkg::OP_ADC) ? ci : 1'b0;
  assign add_sum = {1'b0, a} + {1'b0, b} + {8'd0, add_ci};
  assign add_nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, add_ci};

  assign sub_ci  = (item.opcode == cpualu_pkg::OP_SBC) ? ci : 1'b0;
  assign sub_dif = {1'b0, a} - {1'b0, b} - {8'd0, sub_ci};
  assign sub_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, sub_ci};

  // After a subtraction the adjustment follows the stored flags only.
  assign daa_hi  = ni ? ci : (ci | (a > cpualu_pkg::DAA_HI_MAX));
  assign daa_lo  = ni ? hi : (hi | (a[3:0] > cpualu_pkg::DAA_LO_MAX));
  assign daa_adj = (daa_hi ? cpualu_pkg::DAA_HI_ADJ : 8'h00)
                 | (daa_lo ? cpualu_pkg::DAA_LO_ADJ : 8'h00);
  assign daa_val = ni ? (a - daa_adj) : (a + daa_adj);

  assign bit_mask = 8'h01 << item.bit_index;

  assign w_sum = {1'b0, item.operand_a} + {1'b0, item.operand_b};
  assign w_low = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};

  assign sp_off  = {{8{b[7]}}, b};
  assign sp_sum  = item.operand_a + sp_off;
  assign sp_nib  = {1'b0, item.operand_a[3:0]} + {1'b0, b[3:0]};
  assign sp_byte = {1'b0, item.operand_a[7:0]} + {1'b0, b};

  always_comb begin
    logic [7:0]  r8;
    logic [15:0] r16;
    logic        wide;
    logic        zres;
    logic        z, n, h, c, v;
    r8   = a;
    r16  = 16'd0;
    wide = 1'b0;
    zres = 1'b0;
    z    = zi;
    n    = ni;
    h    = hi;
    c    = ci;
    v    = 1'b1;
    unique case (item.opcode)
      cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC: begin
        r8 = add_sum[7:0]; h = add_nib[4]; c = add_sum[8]; n = 1'b0; zres = 1'b1;
      end
      cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC: begin
        r8 = sub_dif[7:0]; h = sub_nib[4]; c = sub_dif[8]; n = 1'b1; zres = 1'b1;
      end
      cpualu_pkg::OP_CP: begin
        // Flags as for a subtraction, accumulator left as it was.
        h = sub_nib[4]; c = sub_dif[8]; n = 1'b1;
        z = (sub_dif[7:0] == 8'd0); v = 1'b0;
      end
      cpualu_pkg::OP_AND: begin
        r8 = a & b; n = 1'b0; h = 1'b1; c = 1'b0; zres = 1'b1;
      end
      cpualu_pkg::OP_XOR: begin
        r8 = a ^ b; n = 1'b0; h = 1'b0; c = 1'b0; zres = 1'b1;
      end
      cpualu_pkg::OP_OR: begin
        r8 = a | b; n = 1'b0; h = 1'b0; c = 1'b0; zres = 1'b1;
      end
      cpualu_pkg::OP_INC: begin
        r8 = a + 8'd1; h = (a[3:0] == 4'hF); n = 1'b0; zres = 1'b1;
      end
      cpualu_pkg::OP_DEC: begin
        r8 = a - 8'd1; h = (a[3:0] == 4'h0); n = 1'b1; zres = 1'b1;
      end
      cpualu_pkg::OP_DAA: begin
        r8 = daa_val; c = daa_hi; h = 1'b0; zres = 1'b1;
      end
      cpualu_pkg::OP_CPL: begin
        r8 = ~a; n = 1'b1; h = 1'b1;
      end
      cpualu_pkg::OP_SCF: begin
        n = 1'b0; h = 1'b0; c = 1'b1;
      end
      cpualu_pkg::OP_CCF: begin
        n = 1'b0; h = 1'b0; c = ~ci;
      end
      cpualu_pkg::OP_RLCA: begin
        r8 = {a[6:0], a[7]}; c = a[7]; n = 1'b0; h = 1'b0; z = 1'b0;
      end
      cpualu_pkg::OP_RLA: begin
        r8 = {a[6:0], ci}; c = a[7]; n = 1'b0; h = 1'b0; z = 1'b0;
      end
      cpualu_pkg::OP_RRCA: begin
        r8 = {a[0], a[7:1]}; c = a[0]; n = 1'b0; h = 1'b0; z = 1'b0;
      end
      cpualu_pkg::OP_RRA: begin
        r8 = {ci, a[7:1]}; c = a[0]; n = 1'b0; h = 1'b0; z = 1'b0;
      end
      cpualu_pkg::OP_RLC: begin
        r8 = {a[6:0], a[7]}; c = a[7]; n = 1'b0; h = 1'b0; zres = 1'b1;
      end
      cpualu_pkg::OP_RL: begin
        r8 = {a[6:0], ci}; c = a[7]; n = 1'b0; h = 1'b0; zres = 1'b1;
      end
      cpualu_pkg::OP_RRC: begin
        r8 = {a[0], a[7:1]}; c = a[0]; n = 1'b0; h = 1'b0; zres = 1'b1;
      end
      cpualu_pkg::OP_RR: begin
        r8 = {ci, a[7:1]}; c = a[0]; n = 1'b0; h = 1'b0; zres = 1'b1;
      end
      cpualu_pkg::OP_SLA: begin
        r8 = {a[6:0], 1'b0}; c = a[7]; n = 1'b0; h = 1'b0; zres = 1'b1;
      end
      cpualu_pkg::OP_SRA: begin
        r8 = {a[7], a[7:1]}; c = a[0]; n = 1'b0; h = 1'b0; zres = 1'b1;
      end
      cpualu_pkg::OP_SRL: begin
        r8 = {1'b0, a[7:1]}; c = a[0]; n = 1'b0; h = 1'b0; zres = 1'b1;
      end
      cpualu_pkg::OP_SWAP: begin
        r8 = {a[3:0], a[7:4]}; c = 1'b0; n = 1'b0; h = 1'b0; zres = 1'b1;
      end
      cpualu_pkg::OP_BIT: begin
        z = ~a[item.bit_index]; n = 1'b0; h = 1'b1; v = 1'b0;
      end
      cpualu_pkg::OP_RES: begin
        r8 = a & ~bit_mask;
      end
      cpualu_pkg::OP_SET: begin
        r8 = a | bit_mask;
      end
      cpualu_pkg::OP_ADD16: begin
        wide = 1'b1; r16 = w_sum[15:0]; h = w_low[12]; c = w_sum[16]; n = 1'b0;
      end
      cpualu_pkg::OP_ADD_SP: begin
        // Flags come from the unsigned low-byte add, not the signed sum.
        wide = 1'b1; r16 = sp_sum; h = sp_nib[4]; c = sp_byte[8];
        z = 1'b0; n = 1'b0;
      end
      default: begin
        v = 1'b0;
      end
    endcase
    if (zres) begin
      z = (r8 == 8'd0);
    end
    res.result_value = wide ? r16 : {8'd0, r8};
    res.flags_out    = {z, n, h, c};
    res.result_valid = v;
  end

endmodule

// ===== rtl/core/cpu_eight_bit_alu_with_flags_unit.sv =====
// Eight-bit CPU ALU with flags, as used in the execute stage of a small
// handheld-console style core.
//
// Usage: an operation enters on the in_ channel (in_valid / in_ready /
// in_data) and its result leaves on the out_ channel (out_valid /
// out_ready / out_data). Each transfer carries one packed struct from
// cpualu_pkg. Every operation gives exactly one result, in order.
//
// A transfer sits in the input register until the result register can
// load it, and out_valid is high once the result register holds it.
// Throughput is one operation per cycle while out_ready is high; the
// single-pass logic between the two registers sets it.
//
// When the receiver holds out_ready low, the result register keeps its
// contents, the input register still takes one more operation, and only
// then does in_ready fall. Reset (rst_n low, synchronous) empties both
// registers by clearing the two valid bits; the payloads are not reset.
module cpu_eight_bit_alu_with_flags_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cpualu_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cpualu_pkg::out_item_t out_data
);

  // Input register: holds one operation waiting to be evaluated.
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  cpualu_pkg::in_item_t  s1_item_r;

  // Result register: holds one evaluated operation waiting to be taken.
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  cpualu_pkg::out_item_t out_item_r;

  cpualu_pkg::out_item_t exec_out;

  logic in_xfer;
  logic out_xfer;
  logic s2_load;

  // The evaluation logic sits between the two registers.
  cpualu_exec u_exec (
    .item (s1_item_r),
    .res  (exec_out)
  );

  assign out_xfer = out_valid_r & out_ready;

  // The result register can take a new value when it is empty or when its
  // current value leaves in this cycle.
  assign s2_load = s1_valid_r & (~out_valid_r | out_ready);

  // The input register can take a new operation when it is empty or when
  // its current operation moves on to the result register.
  assign in_ready = ~s1_valid_r | s2_load;
  assign in_xfer  = in_valid & in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset; the valid bits qualify them.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_data;
    end
    if (s2_load) begin
      out_item_r <= exec_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // A new operation may only enter a full input register if the held one
  // moves to the result register in the same cycle.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && s1_valid_r |-> s2_load)
    else $error("input register overwritten while full");

  // A stalled, full pipe must refuse new operations.
  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("in_ready high while both registers are stalled");

  // Whatever enters the result register is offered in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |=> out_valid)
    else $error("loaded result not offered");

  // Eight-bit operations leave the high byte of the result clear.
  a_byte_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_item_r.opcode != cpualu_pkg::OP_ADD16
      && s1_item_r.opcode != cpualu_pkg::OP_ADD_SP
    |-> exec_out.result_value[15:8] == 8'd0)
    else $error("eight-bit operation drove the high result byte");

  // Compare and bit test never request a write-back.
  a_no_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && (s1_item_r.opcode == cpualu_pkg::OP_CP
      || s1_item_r.opcode == cpualu_pkg::OP_BIT)
    |-> !exec_out.result_valid)
    else $error("compare or bit test requested a write-back");

endmodule
